FILE: rtl/rmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_pkg
// shared types and constants of the rgb 3x3 median filter
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int WIN_SIZE = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // one window column: top is the newest row
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // per request control travelling with the window
  typedef struct packed {
    logic [WIN_SIZE-1:0] mask;
    logic [3:0]          half;
    logic                last;
  } win_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/rmf_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_line_store
// two line history in one memory, read on accept, written back as the request leaves the read stage
// ----------------------------------------------------------------------------
module rmf_line_store #(
  parameter int MAX_WIDTH = 2048,
  parameter int CW = 11
) (
  input  wire                   clk,
  input  wire                   rd_en,
  input  wire  [CW-1:0]         rd_col,
  input  wire                   wr_en,
  input  wire  [CW-1:0]         wr_col,
  input  rmf_pkg::pixel_t       wr_pix,
  input  rmf_pkg::column_t      prev_col,
  output rmf_pkg::column_t      new_col
);
  import rmf_pkg::*;

  // upper half: last row, lower half: row before
  logic [2*$bits(pixel_t)-1:0] mem [MAX_WIDTH];
  logic [2*$bits(pixel_t)-1:0] rd_data_r;
  logic                        fwd_r;
  logic                        fwd_nxt;
  pixel_t                      above;
  pixel_t                      above2;

  assign fwd_nxt = wr_en && (wr_col == rd_col);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_col];
      fwd_r     <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_col] <= {wr_pix, above};
    end
  end

  // same column written back on the accept edge: take it from the window
  always_comb begin
    if (fwd_r) begin
      above  = prev_col.top;
      above2 = prev_col.mid;
    end else begin
      above  = rd_data_r[2*$bits(pixel_t)-1:$bits(pixel_t)];
      above2 = rd_data_r[$bits(pixel_t)-1:0];
    end
    new_col.top = wr_pix;
    new_col.mid = above;
    new_col.bot = above2;
  end

endmodule
`default_nettype wire

FILE: rtl/rmf_rank_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_rank_select
// pairwise compare stage then rank count and pick, per colour channel
// ----------------------------------------------------------------------------
module rmf_rank_select (
  input  wire                             clk,
  input  wire                             ld_cmp,
  input  wire                             ld_out,
  input  rmf_pkg::pixel_t [rmf_pkg::WIN_SIZE-1:0] win,
  input  rmf_pkg::win_ctl_t               ctl,
  output rmf_pkg::pixel_t                 pix_out,
  output logic                            last_out
);
  import rmf_pkg::*;

  logic [7:0]          val    [3][WIN_SIZE];
  logic [WIN_SIZE-1:0] pre_nxt[3][WIN_SIZE];
  logic [7:0]          val_r  [3][WIN_SIZE];
  logic [WIN_SIZE-1:0] pre_r  [3][WIN_SIZE];
  win_ctl_t            ctl_r;
  logic [7:0]          med_nxt[3];
  pixel_t              pix_r;
  logic                last_r;

  always_comb begin
    for (int i = 0; i < WIN_SIZE; i++) begin
      val[0][i] = win[i].red;
      val[1][i] = win[i].green;
      val[2][i] = win[i].blue;
    end
    // element j ranks below element i, ties broken by position
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        for (int j = 0; j < WIN_SIZE; j++) begin
          pre_nxt[c][i][j] = ctl.mask[j] &&
            ((val[c][j] < val[c][i]) || ((val[c][j] == val[c][i]) && (j < i)));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_cmp) begin
      val_r <= val;
      pre_r <= pre_nxt;
      ctl_r <= ctl;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      med_nxt[c] = '0;
      for (int i = 0; i < WIN_SIZE; i++) begin
        if (ctl_r.mask[i] && (4'($countones(pre_r[c][i])) == ctl_r.half)) begin
          med_nxt[c] = med_nxt[c] | val_r[c][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      pix_r.red   <= med_nxt[0];
      pix_r.green <= med_nxt[1];
      pix_r.blue  <= med_nxt[2];
      last_r      <= ctl_r.last;
    end
  end

  assign pix_out  = pix_r;
  assign last_out = last_r;

endmodule
`default_nettype wire

FILE: rtl/rgb_median_3x3_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_median_3x3_filter
// streaming 3x3 median on rgb pixels with a two line memory history
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  in       in_valid/in_ready  in_operation, in_red_in, in_green_in, in_blue_in
//  out      out_valid/out_ready out_red_out, out_green_out, out_blue_out,
//                              out_frame_end
//  cfg      cfg_we             cfg_index, cfg_wdata
//
//  one request per cycle while in_ready is high; the result of the request
//  that completes a window passes memory read, window, compare and rank pick
//  the line memory is read on accept and written back as the request leaves
//  the read stage
//  reset is synchronous; the line memory needs no clearing
//  a stalled result holds the stages behind it, empty stages still fill
// ----------------------------------------------------------------------------
module rgb_median_3x3_filter #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_operation,
  input  wire  [7:0]                       in_red_in,
  input  wire  [7:0]                       in_green_in,
  input  wire  [7:0]                       in_blue_in,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [7:0]                       out_red_out,
  output logic [7:0]                       out_green_out,
  output logic [7:0]                       out_blue_out,
  output logic                             out_frame_end,
  input  wire                              cfg_we,
  input  wire  [rmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [rmf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rmf_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > 12) ? WW : 12;

  logic [11:0]    width_r;
  logic [15:0]    height_r;
  logic [CW-1:0]  in_col_r,  in_col_nxt;
  logic [16:0]    in_row_r,  in_row_nxt;
  logic [CW-1:0]  out_col_r, out_col_nxt;
  logic [15:0]    out_row_r, out_row_nxt;

  logic [XW-1:0]  width_x;
  logic [WW-1:0]  w_eff, w_m1;
  logic [15:0]    h_eff, h_m1;
  logic           accept, in_frame, started, last_pos;
  pixel_t         in_pix;
  logic [2:0]     row_ok, col_ok;
  win_ctl_t       ctl_nxt;

  // stage a: memory read in flight
  logic           va_r, res_a_r;
  win_ctl_t       ctl_a_r;
  logic [CW-1:0]  col_a_r;
  pixel_t         pix_a_r;
  // stage b: window, stage c: compare, stage d: output
  logic           vb_r, vc_r, vd_r;
  win_ctl_t       ctl_b_r;
  column_t        win_col_r [3];
  column_t        new_col;
  pixel_t [WIN_SIZE-1:0] win;
  logic           free_a, free_b, free_c, free_d, move_a;
  pixel_t         med_pix;

  assign free_d   = !vd_r || out_ready;
  assign free_c   = !vc_r || free_d;
  assign free_b   = !vb_r || free_c;
  assign free_a   = !va_r || free_b;
  assign move_a   = va_r && free_b;
  assign in_ready = free_a;
  assign accept   = in_valid && free_a;

  assign width_x = XW'(width_r);
  always_comb begin
    if (width_x == '0) begin
      w_eff = WW'(1);
    end else if (width_x > XW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_x);
    end
    h_eff = (height_r == '0) ? 16'd1 : height_r;
  end
  assign w_m1 = w_eff - WW'(1);
  assign h_m1 = h_eff - 16'd1;

  assign in_frame = in_row_r < {1'b0, h_eff};
  assign started  = (in_row_r > 17'd1) || ((in_row_r == 17'd1) && (in_col_r != '0));
  assign last_pos = (out_row_r == h_m1) && (WW'(out_col_r) == w_m1);

  always_comb begin
    if ((in_operation == OP_PIXEL) && in_frame) begin
      in_pix = {in_red_in, in_green_in, in_blue_in};
    end else begin
      in_pix = '0;
    end
    row_ok = {out_row_r != h_m1, 1'b1, out_row_r != '0};
    col_ok = {WW'(out_col_r) != w_m1, 1'b1, out_col_r != '0};
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ctl_nxt.mask[r*3+c] = row_ok[r] && col_ok[c];
      end
    end
    ctl_nxt.half = 4'($countones(ctl_nxt.mask)) >> 1;
    ctl_nxt.last = last_pos;
  end

  // position counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (accept) begin
      if (started && last_pos) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        if (started) begin
          if (WW'(out_col_r) == w_m1) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + 16'd1;
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
        end
        if (WW'(in_col_r) == w_m1) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + 17'd1;
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
      end
    end
    if (cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 12'd640;
      height_r  <= 16'd480;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      vc_r      <= 1'b0;
      vd_r      <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  width_r  <= cfg_wdata[11:0];
          CFG_FRAME_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (free_a) va_r <= in_valid;
      if (free_b) vb_r <= va_r && res_a_r;
      if (free_c) vc_r <= vb_r;
      if (free_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_a_r <= started;
      ctl_a_r <= ctl_nxt;
      col_a_r <= in_col_r;
      pix_a_r <= in_pix;
    end
    if (free_b) begin
      ctl_b_r <= ctl_a_r;
    end
    if (move_a) begin
      win_col_r[0] <= win_col_r[1];
      win_col_r[1] <= win_col_r[2];
      win_col_r[2] <= new_col;
    end
  end

  rmf_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (accept),
    .rd_col   (in_col_r),
    .wr_en    (move_a),
    .wr_col   (col_a_r),
    .wr_pix   (pix_a_r),
    .prev_col (win_col_r[2]),
    .new_col  (new_col)
  );

  // window index: row (bot, mid, top) times 3 plus column (left to right)
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      win[c]     = win_col_r[c].bot;
      win[3 + c] = win_col_r[c].mid;
      win[6 + c] = win_col_r[c].top;
    end
  end

  rmf_rank_select u_rank_select (
    .clk      (clk),
    .ld_cmp   (vb_r && free_c),
    .ld_out   (vc_r && free_d),
    .win      (win),
    .ctl      (ctl_b_r),
    .pix_out  (med_pix),
    .last_out (out_frame_end)
  );

  assign out_valid     = vd_r;
  assign out_red_out   = med_pix.red;
  assign out_green_out = med_pix.green;
  assign out_blue_out  = med_pix.blue;

endmodule
`default_nettype wire

FILE: rtl/rmf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmf_checker
// port level checks of the median filter, bound to the top level
// ----------------------------------------------------------------------------
module rmf_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_red_out,
  input wire [7:0] out_green_out,
  input wire [7:0] out_blue_out,
  input wire       out_frame_end
);

  // a free output stage frees the whole pipe
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked with free output stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_red_out) && $stable(out_green_out) &&
                                   $stable(out_blue_out) && $stable(out_frame_end)))
    else $error("stalled result changed");

endmodule

bind rgb_median_3x3_filter rmf_checker u_rmf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out),
  .out_frame_end (out_frame_end)
);
`default_nettype wire

FILE: dv/rmf_median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_median_checker
// watches the pixel, result and register ports of the rgb 3x3 median filter,
// keeps its own copy of the row history and frame positions, works out the
// median expected for each request that completes a window and compares each
// against the oldest one still outstanding
// ----------------------------------------------------------------------------
module rmf_median_checker #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  input  wire                            in_ready,
  input  wire                            in_operation,
  input  wire  [7:0]                     in_red_in,
  input  wire  [7:0]                     in_green_in,
  input  wire  [7:0]                     in_blue_in,
  input  wire                            out_valid,
  input  wire                            out_ready,
  input  wire  [7:0]                     out_red_out,
  input  wire  [7:0]                     out_green_out,
  input  wire  [7:0]                     out_blue_out,
  input  wire                            out_frame_end,
  input  wire                            cfg_we,
  input  wire  [rmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [rmf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             n_fail,
  output int                             n_pending,
  output int                             n_results
);
  import rmf_pkg::*;

  localparam int HIST = 2 * MAX_WIDTH + 3;

  typedef struct packed {
    pixel_t px;
    logic   fend;
  } median_t;

  median_t     median_q[$];
  pixel_t      history[HIST];
  logic [11:0] width_reg;
  logic [15:0] height_reg;
  int unsigned wr_ptr, in_row, in_col, out_row, out_col;
  int          n_printed;

  task automatic report_mismatch(input string what, input int got, input int want);
    n_fail++;
    if (n_printed < 40) begin
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    end
    n_printed++;
  endtask

  function automatic logic [7:0] rank_pick(input logic [7:0] v[WIN_SIZE], input int n);
    logic [7:0] t;
    int j;
    for (int i = 1; i < n; i++) begin
      t = v[i];
      j = i;
      while (j > 0 && v[j-1] > t) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = t;
    end
    return v[n/2];
  endfunction

  task automatic restart_frame();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endtask

  task automatic filter_step(input logic op, input pixel_t px_in);
    int unsigned w, h, n;
    int nr, nc, off;
    bit started, last;
    pixel_t px;
    pixel_t win[WIN_SIZE];
    logic [7:0] rv[WIN_SIZE], gv[WIN_SIZE], bv[WIN_SIZE];
    median_t m;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    px = (op != OP_PIXEL || in_row >= h) ? '0 : px_in;
    wr_ptr = (wr_ptr + 1) % HIST;
    history[wr_ptr] = px;
    started = (in_row > 1) || (in_row == 1 && in_col >= 1);
    if (started) begin
      n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          nr = int'(out_row) + dr;
          nc = int'(out_col) + dc;
          if (nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w)) begin
            off = int'(w) + 1 - dr * int'(w) - dc;
            win[n] = history[(wr_ptr + HIST - off) % HIST];
            rv[n] = win[n].red;
            gv[n] = win[n].green;
            bv[n] = win[n].blue;
            n++;
          end
        end
      end
      m.px.red = rank_pick(rv, n);
      m.px.green = rank_pick(gv, n);
      m.px.blue = rank_pick(bv, n);
      last = (out_row == h - 1) && (out_col == w - 1);
      m.fend = last;
      median_q.push_back(m);
      if (last) begin
        restart_frame();
        return;
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
  endtask

  always @(posedge clk) begin
    median_t want;
    if (!rst_n) begin
      width_reg = 12'd640;
      height_reg = 16'd480;
      wr_ptr = 0;
      restart_frame();
      median_q.delete();
      n_fail = 0;
      n_results = 0;
      n_printed = 0;
      for (int i = 0; i < HIST; i++) history[i] = '0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (median_q.size() == 0) begin
          report_mismatch("unexpected result, frame_end", int'(out_frame_end), 0);
        end else begin
          want = median_q.pop_front();
          if (out_red_out !== want.px.red)
            report_mismatch("red", int'(out_red_out), int'(want.px.red));
          if (out_green_out !== want.px.green)
            report_mismatch("green", int'(out_green_out), int'(want.px.green));
          if (out_blue_out !== want.px.blue)
            report_mismatch("blue", int'(out_blue_out), int'(want.px.blue));
          if (out_frame_end !== want.fend)
            report_mismatch("frame_end", int'(out_frame_end), int'(want.fend));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH: begin
            width_reg = cfg_wdata[11:0];
          end
          CFG_FRAME_HEIGHT: begin
            height_reg = cfg_wdata[15:0];
          end
          default: ;
        endcase
        restart_frame();
      end
      if (in_valid && in_ready) begin
        filter_step(in_operation, {in_red_in, in_green_in, in_blue_in});
      end
    end
    n_pending = median_q.size();
  end

endmodule

FILE: dv/rgb_median_3x3_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_median_3x3_filter_tb
// drives frames of random and extreme pixels through the median filter under
// many frame sizes, with early flushes, late pixels, restarts by register
// writes and random stalls on both sides; a checker beside the block predicts
// and compares every result
// ----------------------------------------------------------------------------
module rgb_median_3x3_filter_tb;
  import rmf_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_operation;
  logic [7:0]            in_red_in, in_green_in, in_blue_in;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_red_out, out_green_out, out_blue_out;
  logic                  out_frame_end;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    n_fail, n_pending, n_results;
  int                    n_requests, n_frames, n_writes, idle_cycles;
  bit                    long_hold_done;

  rgb_median_3x3_filter dut (.*);

  rmf_median_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure, one long hold once results are flowing
  initial begin
    out_ready = 1'b0;
    long_hold_done = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && n_results >= 40 && in_valid) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold_done = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60))
          @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 4000) begin
        $display("watchdog expired with %0d results outstanding", n_pending);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  task automatic send_request(input logic op, input logic [7:0] r, g, b);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap = (pick < 60) ? 0 : ((pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_requests++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_frame(input logic [15:0] w, input logic [15:0] h);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  function automatic logic [7:0] chan_value();
    int pick;
    pick = $urandom_range(0, 9);
    return (pick == 0) ? 8'h00 : ((pick == 1) ? 8'hff : 8'($urandom));
  endfunction

  // style: 0 clean, 1 early flushes, 2 late pixels, 3 random operations
  task automatic run_frame(input int w, input int h, input int style);
    logic op;
    for (int q = 0; q <= w * h + w; q++) begin
      op = (q >= w * h) ? ~OP_PIXEL : OP_PIXEL;
      if (style == 1 && q < w * h && $urandom_range(0, 7) == 0) op = ~OP_PIXEL;
      if (style == 2 && q >= w * h && $urandom_range(0, 1) == 0) op = OP_PIXEL;
      if (style == 3) op = 1'($urandom_range(0, 1));
      send_request(op, chan_value(), chan_value(), chan_value());
    end
    n_frames++;
  endtask

  initial begin
    int w, h, w_raw, h_raw, phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_PIXEL;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    n_requests = 0;
    n_frames = 0;
    n_writes = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 frame of extremes with an early flush in the middle
    set_frame(16'd3, 16'd3);
    send_request(OP_PIXEL, 8'h00, 8'hff, 8'h00);
    send_request(OP_PIXEL, 8'hff, 8'h00, 8'hff);
    send_request(OP_PIXEL, 8'haa, 8'h55, 8'haa);
    send_request(OP_PIXEL, 8'h55, 8'haa, 8'h55);
    send_request(~OP_PIXEL, 8'hff, 8'hff, 8'hff);
    send_request(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    send_request(OP_PIXEL, 8'h01, 8'h80, 8'hfe);
    send_request(OP_PIXEL, 8'h7f, 8'hfe, 8'h01);
    send_request(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 4; i++) send_request(~OP_PIXEL, 8'h00, 8'h00, 8'h00);
    // zero sizes act as one, late pixel in the flush part
    set_frame(16'd0, 16'd0);
    send_request(OP_PIXEL, 8'hff, 8'h00, 8'h7f);
    send_request(OP_PIXEL, 8'h12, 8'h34, 8'h56);
    send_request(~OP_PIXEL, 8'h00, 8'h00, 8'h00);
    set_frame(16'd1, 16'd2);
    run_frame(1, 2, 0);
    n_frames += 2;

    phase = 0;
    while (n_requests < 1750) begin
      phase++;
      if (phase == 4) begin
        // width register all ones clamps to the widest row; the row never fills
        set_frame(16'hffff, 16'd2);
        for (int i = 0; i < 160; i++) send_request(OP_PIXEL, chan_value(), chan_value(),
                                                   chan_value());
      end else if (phase == 7) begin
        // tallest frame never completes; the next write restarts it
        set_frame(16'd3, 16'hffff);
        for (int i = 0; i < 40; i++) send_request(OP_PIXEL, chan_value(), chan_value(),
                                                  chan_value());
      end else begin
        w_raw = ($urandom_range(0, 9) == 0) ? 0 :
                (($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
        h_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        w = (w_raw == 0) ? 1 : w_raw;
        h = (h_raw == 0) ? 1 : h_raw;
        set_frame(16'(w_raw), 16'(h_raw));
        repeat ($urandom_range(1, 3)) begin
          run_frame(w, h, ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3));
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d requests over %0d frames with %0d register writes", n_requests,
             n_frames, n_writes);
    $display("received %0d results, %0d still outstanding", n_results, n_pending);
    if (n_fail == 0 && n_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rmf_pkg.sv
rtl/rmf_line_store.sv
rtl/rmf_rank_select.sv
rtl/rgb_median_3x3_filter.sv
rtl/rmf_checker.sv
dv/rmf_median_checker.sv
dv/rgb_median_3x3_filter_tb.sv
